/* rtl/udc_pkg.sv */
// Shared types, constants and helpers for the UDP datagram checker.
`timescale 1ns / 1ps
package udc_pkg;

  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0] HDR_BYTES = LEN_BITS'(8);
  localparam logic [15:0] UDP_PROTO = 16'd17;
  localparam logic [15:0] SUM_GOOD = 16'hFFFF;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_LEN_LONG  = 3'd2;
  localparam logic [2:0] ST_LEN_SMALL = 3'd3;
  localparam logic [2:0] ST_BAD_SUM   = 3'd4;

  typedef struct packed {
    logic [LEN_BITS-1:0] count;
    logic [15:0]         hdr_len;
    logic [15:0]         source_port;
    logic [15:0]         dst_port;
    logic [15:0]         cksum;
    logic [15:0]         sum;
    logic [7:0]          held;
    logic [31:0]         source_addr;
    logic [31:0]         dst_addr;
  } job_t;

  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

/* rtl/udc_front.sv */
// Byte intake: header capture and running ones' complement sum.
`timescale 1ns / 1ps
module udc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           pkt_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  input  logic [31:0]          source_addr,
  input  logic [31:0]          dst_addr,
  output logic                 push,
  output udc_pkg::job_t        job
);
  import udc_pkg::*;

  logic [LEN_BITS-1:0] byte_count_r, byte_count_nxt, pos;
  logic [15:0] sum_r, sum_nxt, source_port_r, source_port_nxt, dst_port_r, dst_port_nxt;
  logic [15:0] len_r, len_nxt, cksum_r, cksum_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [31:0] saddr_r, saddr_nxt, daddr_r, daddr_nxt;
  logic        sat;

  always_comb begin
    pos             = first_byte ? '0 : byte_count_r;
    sum_nxt         = first_byte ? '0 : sum_r;
    held_nxt        = first_byte ? '0 : held_r;
    source_port_nxt = first_byte ? '0 : source_port_r;
    dst_port_nxt    = first_byte ? '0 : dst_port_r;
    len_nxt         = first_byte ? '0 : len_r;
    cksum_nxt       = first_byte ? '0 : cksum_r;
    saddr_nxt       = first_byte ? source_addr : saddr_r;
    daddr_nxt       = first_byte ? dst_addr : daddr_r;
    sat             = (pos == LEN_MAX);
    byte_count_nxt  = sat ? pos : pos + LEN_BITS'(1);
    if (!sat) begin
      if (pos < HDR_BYTES) begin
        case (pos[2:0])
          3'd0: source_port_nxt = {pkt_byte, 8'h00};
          3'd1: source_port_nxt = {source_port_nxt[15:8], pkt_byte};
          3'd2: dst_port_nxt = {pkt_byte, 8'h00};
          3'd3: dst_port_nxt = {dst_port_nxt[15:8], pkt_byte};
          3'd4: len_nxt = {pkt_byte, 8'h00};
          3'd5: len_nxt = {len_nxt[15:8], pkt_byte};
          3'd6: cksum_nxt = {pkt_byte, 8'h00};
          3'd7: cksum_nxt = {cksum_nxt[15:8], pkt_byte};
          default: ;
        endcase
      end
      if (pos < HDR_BYTES || pos < len_nxt) begin
        if (!pos[0]) begin
          held_nxt = pkt_byte;
        end else begin
          sum_nxt = oc_add(sum_nxt, {held_nxt, pkt_byte});
        end
      end
    end
  end

  assign push = take && last_byte;

  always_comb begin
    job.count       = byte_count_nxt;
    job.hdr_len     = len_nxt;
    job.source_port = source_port_nxt;
    job.dst_port    = dst_port_nxt;
    job.cksum       = cksum_nxt;
    job.sum         = sum_nxt;
    job.held        = held_nxt;
    job.source_addr = saddr_nxt;
    job.dst_addr    = daddr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      sum_r         <= '0;
      held_r        <= '0;
      source_port_r <= '0;
      dst_port_r    <= '0;
      len_r         <= '0;
      cksum_r       <= '0;
      saddr_r       <= '0;
      daddr_r       <= '0;
    end else if (take) begin
      saddr_r <= saddr_nxt;
      daddr_r <= daddr_nxt;
      if (last_byte) begin
        byte_count_r  <= '0;
        sum_r         <= '0;
        held_r        <= '0;
        source_port_r <= '0;
        dst_port_r    <= '0;
        len_r         <= '0;
        cksum_r       <= '0;
      end else begin
        byte_count_r  <= byte_count_nxt;
        sum_r         <= sum_nxt;
        held_r        <= held_nxt;
        source_port_r <= source_port_nxt;
        dst_port_r    <= dst_port_nxt;
        len_r         <= len_nxt;
        cksum_r       <= cksum_nxt;
      end
    end
  end

endmodule

/* rtl/udc_queue.sv */
// Short request queue between the byte intake and the verdict pipeline.
`timescale 1ns / 1ps
module udc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  udc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_vld,
  output udc_pkg::job_t head_job
);
  import udc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t              mem_r [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [PW:0]       count_r;

  assign full     = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head_vld = (count_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (PW+1)'(1);
        2'b01:   count_r <= count_r - (PW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* rtl/udc_back.sv */
// Verdict pipeline: pseudo-header sum, length checks and result register.
`timescale 1ns / 1ps
module udc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_vld,
  input  udc_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic          out_checksum_skipped,
  output logic [15:0]   out_source_port,
  output logic [15:0]   out_dest_port,
  output logic [15:0]   out_payload_len
);
  import udc_pkg::*;

  logic        a_vld_r, out_vld_r, a_ready, b_load;
  logic [17:0] s1_r, s2_r;
  logic [2:0]  a_status_r;
  logic        a_check_r, a_skip_r;
  logic [15:0] a_sport_r, a_dport_r, a_plen_r;
  logic [2:0]  a_status;
  logic [15:0] pad;
  logic [18:0] t;
  logic [16:0] f;
  logic [15:0] total;
  logic [2:0]  b_status;

  assign b_load  = a_vld_r && (!out_vld_r || out_ready);
  assign a_ready = !a_vld_r || b_load;
  assign pop     = head_vld && a_ready;

  always_comb begin
    pad = head_job.hdr_len[0] ? {head_job.held, 8'h00} : 16'h0000;
    if (head_job.count < HDR_BYTES) begin
      a_status = ST_SHORT;
    end else if (head_job.hdr_len > head_job.count) begin
      a_status = ST_LEN_LONG;
    end else if (head_job.hdr_len < HDR_BYTES) begin
      a_status = ST_LEN_SMALL;
    end else begin
      a_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r <= {2'b00, head_job.sum} + {2'b00, pad}
            + {2'b00, head_job.source_addr[31:16]} + {2'b00, head_job.source_addr[15:0]};
      s2_r <= {2'b00, head_job.dst_addr[31:16]} + {2'b00, head_job.dst_addr[15:0]}
            + {2'b00, UDP_PROTO} + {2'b00, head_job.hdr_len};
      a_status_r <= a_status;
      a_check_r  <= (a_status == ST_OK);
      a_skip_r   <= (head_job.cksum == 16'h0000);
      a_sport_r  <= head_job.source_port;
      a_dport_r  <= head_job.dst_port;
      a_plen_r   <= head_job.hdr_len - 16'd8;
    end
  end

  always_comb begin
    t     = {1'b0, s1_r} + {1'b0, s2_r};
    f     = {1'b0, t[15:0]} + {14'b0, t[18:16]};
    total = f[15:0] + {15'b0, f[16]};
    if (!a_check_r) begin
      b_status = a_status_r;
    end else if (!a_skip_r && total != SUM_GOOD) begin
      b_status = ST_BAD_SUM;
    end else begin
      b_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_r <= head_vld;
      end
      if (b_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      out_status           <= b_status;
      out_checksum_skipped <= (b_status == ST_OK) && a_skip_r;
      out_source_port      <= a_sport_r;
      out_dest_port        <= a_dport_r;
      out_payload_len      <= (b_status == ST_OK) ? a_plen_r : 16'h0000;
    end
  end

  assign out_valid = out_vld_r;

`ifndef SYNTHESIS
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BAD_SUM) else $error("status code out of range");
  a_skip_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_skipped |-> out_status == ST_OK)
    else $error("checksum skip flagged on failed verdict");
  a_plen_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_payload_len == 16'h0000)
    else $error("payload length on failed verdict");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    b_load |=> out_valid) else $error("verdict load lost");
`endif

endmodule

/* rtl/udp_datagram_check.sv */
// Top level of the UDP datagram checker.
// Throughput: one byte request per cycle while the request queue is not full, across datagram boundaries.
// After the last byte is accepted, the verdict passes through the request queue entry,
//   the pseudo-header sum stage and the result register before it is valid.
// A two-entry request queue lets bytes flow while verdicts wait at the output.
// Synchronous active-low reset clears the byte count, sum, header and addresses.
`timescale 1ns / 1ps
module udp_datagram_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_source_addr,
  input  logic [31:0] in_dst_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_checksum_skipped,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [15:0] out_payload_len
);
  import udc_pkg::*;

  logic  take, push, full, pop, head_vld;
  job_t  push_job, head_job;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;

  udc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .pkt_byte    (in_pkt_byte),
    .first_byte  (in_first_byte),
    .last_byte   (in_last_byte),
    .source_addr (in_source_addr),
    .dst_addr    (in_dst_addr),
    .push        (push),
    .job         (push_job)
  );

  udc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_vld (head_vld),
    .head_job (head_job)
  );

  udc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head_vld             (head_vld),
    .head_job             (head_job),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_checksum_skipped (out_checksum_skipped),
    .out_source_port      (out_source_port),
    .out_dest_port        (out_dest_port),
    .out_payload_len      (out_payload_len)
  );

endmodule
